[rtl/gtg_pkg.sv]
// gtg_pkg: command codes, register indexes, reset values and tables
// for the go-to-goal velocity controller; no dependencies
`timescale 1ns / 1ps
package gtg_pkg;

    // input word command codes
    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_OPERATOR = 2'd1;
    localparam logic [1:0] CMD_POSE     = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DIST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_GAIN    = 3'd5;

    // register reset values
    localparam logic [31:0] RST_TIMEOUT     = 32'd30000;
    localparam logic [30:0] RST_STOP_DIST   = 31'd3277;
    localparam logic [17:0] RST_SLOW_THRESH = 18'd32768;
    localparam logic [23:0] RST_LIN_GAIN    = 24'd65536;
    localparam logic [23:0] RST_ANG_GAIN    = 24'd262144;

    // pi in Q2.30, binary angle to radians scale
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [31:0] OUT_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic        clock_mode;
        logic [31:0] operator_timeout_ms;
        logic [30:0] stop_distance;
        logic [17:0] slow_heading_threshold;
        logic [23:0] linear_gain;
        logic [23:0] angular_gain;
    } cfg_t;

    // arctangent of 2^-i in 32-bit binary angle
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/gtg_if.sv]
// gtg_if: valid/ready channel interfaces for input, result and config words
// depends on gtg_pkg for the register index width
`timescale 1ns / 1ps
interface gtg_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int QUAT_WIDTH  = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [31:0]                   time_ms;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [QUAT_WIDTH-1:0]  quat_x;
    logic signed [QUAT_WIDTH-1:0]  quat_y;
    logic signed [QUAT_WIDTH-1:0]  quat_z;
    logic signed [QUAT_WIDTH-1:0]  quat_w;

    modport source (output valid, command, time_ms, pos_x, pos_y,
                    quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, command, time_ms, pos_x, pos_y,
                  quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface gtg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fwd_speed;
    logic signed [31:0] turn_rate;
    logic               stopped;

    modport source (output valid, fwd_speed, turn_rate, stopped,
                    input ready);
    modport sink (input valid, fwd_speed, turn_rate, stopped,
                  output ready);
endinterface

interface gtg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gtg_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/gtg_front.sv]
// gtg_front: accepts input words, keeps targets and config registers,
// selects the target and pushes pose jobs; depends on gtg_pkg, gtg_if
`timescale 1ns / 1ps
module gtg_front #(
    parameter int COORD_WIDTH = 32,
    parameter int QUAT_WIDTH  = 16,
    parameter int QDW         = 2 * (COORD_WIDTH + 1) + 4 * QUAT_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    gtg_in_if.sink          in_ch,
    gtg_cfg_if.sink         cfg_ch,
    output gtg_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            q_push,
    output logic [QDW-1:0]  q_data
);
    import gtg_pkg::*;

    localparam int DW     = COORD_WIDTH + 1;
    localparam int QSHIFT = (QUAT_WIDTH > 30) ? QUAT_WIDTH - 30 : 0;
    localparam int QE     = QUAT_WIDTH - QSHIFT;

    cfg_t                          cfg_reg;
    logic signed [COORD_WIDTH-1:0] sched_x_reg, sched_y_reg;
    logic signed [COORD_WIDTH-1:0] oper_x_reg, oper_y_reg;
    logic [31:0]                   oper_time_reg;
    logic                          oper_valid_reg;

    logic                          accept;
    logic                          use_oper;
    logic [31:0]                   age;
    logic signed [COORD_WIDTH-1:0] tx, ty;
    logic signed [DW-1:0]          dx, dy;
    logic signed [QE-1:0]          qx, qy, qz, qw;

    assign cfg          = cfg_reg;
    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !q_full;
    assign accept       = in_ch.valid && !q_full;

    // target choice and offset to the target
    always_comb
    begin
        age      = in_ch.time_ms - oper_time_reg;
        use_oper = !cfg_reg.clock_mode && oper_valid_reg &&
                   (age < cfg_reg.operator_timeout_ms);
        tx = use_oper ? oper_x_reg : sched_x_reg;
        ty = use_oper ? oper_y_reg : sched_y_reg;
        dx = DW'(tx) - DW'(in_ch.pos_x);
        dy = DW'(ty) - DW'(in_ch.pos_y);
        qx = QE'(in_ch.quat_x >>> QSHIFT);
        qy = QE'(in_ch.quat_y >>> QSHIFT);
        qz = QE'(in_ch.quat_z >>> QSHIFT);
        qw = QE'(in_ch.quat_w >>> QSHIFT);
    end

    assign q_push = accept && (in_ch.command == CMD_POSE);
    assign q_data = {dx, dy, qx, qy, qz, qw};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_mode             <= 1'b1;
            cfg_reg.operator_timeout_ms    <= RST_TIMEOUT;
            cfg_reg.stop_distance          <= RST_STOP_DIST;
            cfg_reg.slow_heading_threshold <= RST_SLOW_THRESH;
            cfg_reg.linear_gain            <= RST_LIN_GAIN;
            cfg_reg.angular_gain           <= RST_ANG_GAIN;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_CLOCK_MODE:  cfg_reg.clock_mode <= cfg_ch.data[0];
                REG_TIMEOUT:     cfg_reg.operator_timeout_ms <= cfg_ch.data;
                REG_STOP_DIST:   cfg_reg.stop_distance <= cfg_ch.data[30:0];
                REG_SLOW_THRESH: cfg_reg.slow_heading_threshold <= cfg_ch.data[17:0];
                REG_LIN_GAIN:    cfg_reg.linear_gain <= cfg_ch.data[23:0];
                REG_ANG_GAIN:    cfg_reg.angular_gain <= cfg_ch.data[23:0];
                default:         ;
            endcase
        end
    end

    // target updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_x_reg    <= '0;
            sched_y_reg    <= '0;
            oper_x_reg     <= '0;
            oper_y_reg     <= '0;
            oper_time_reg  <= '0;
            oper_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            case (in_ch.command)
                CMD_SCHEDULE:
                begin
                    sched_x_reg <= in_ch.pos_x;
                    sched_y_reg <= in_ch.pos_y;
                end
                CMD_OPERATOR:
                begin
                    oper_x_reg     <= in_ch.pos_x;
                    oper_y_reg     <= in_ch.pos_y;
                    oper_time_reg  <= in_ch.time_ms;
                    oper_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

[rtl/gtg_queue.sv]
// gtg_queue: two-entry job queue between front and back
// no dependencies
`timescale 1ns / 1ps
module gtg_queue #(
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output logic [DW-1:0] pop_data
);
    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/gtg_cordic.sv]
// gtg_cordic: iterative vectoring cordic, one rotation per cycle,
// returns a 32-bit binary angle; depends on gtg_pkg
`timescale 1ns / 1ps
module gtg_cordic #(
    parameter int W     = 66,
    parameter int STEPS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    output logic                done,
    output logic [31:0]         angle
);
    import gtg_pkg::*;

    localparam logic [4:0] LAST = 5'(STEPS - 1);

    logic signed [W-1:0] x_reg, y_reg;
    logic signed [W-1:0] xs, ys;
    logic [31:0]         z_reg;
    logic [4:0]          i_reg;
    logic                busy_reg, done_reg;

    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    assign done  = done_reg;
    assign angle = z_reg;

    // control and datapath of the rotation loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                i_reg <= '0;
                if (x_in == '0 && y_in == '0)
                begin
                    z_reg    <= '0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    // bring the vector into the right half plane
                    if (x_in < 0)
                    begin
                        if (y_in >= 0)
                        begin
                            x_reg <= y_in;
                            y_reg <= -x_in;
                            z_reg <= 32'h4000_0000;
                        end
                        else
                        begin
                            x_reg <= -y_in;
                            y_reg <= x_in;
                            z_reg <= 32'hC000_0000;
                        end
                    end
                    else
                    begin
                        x_reg <= x_in;
                        y_reg <= y_in;
                        z_reg <= '0;
                    end
                end
            end
            else if (busy_reg)
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_lut(i_reg);
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_lut(i_reg);
                end
                i_reg <= i_reg + 5'd1;
                if (i_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/gtg_back.sv]
// gtg_back: pose job sequencer: distance root, yaw and bearing via the
// shared cordic, gains and result register; depends on gtg_pkg, gtg_if, gtg_cordic
`timescale 1ns / 1ps
module gtg_back #(
    parameter int COORD_WIDTH  = 32,
    parameter int QUAT_WIDTH   = 16,
    parameter int CORDIC_STEPS = 24,
    parameter int QDW          = 2 * (COORD_WIDTH + 1) + 4 * QUAT_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gtg_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  logic [QDW-1:0]  q_data,
    output logic            q_pop,
    gtg_out_if.source       out_ch
);
    import gtg_pkg::*;

    localparam int DW     = COORD_WIDTH + 1;
    localparam int QSHIFT = (QUAT_WIDTH > 30) ? QUAT_WIDTH - 30 : 0;
    localparam int QE     = QUAT_WIDTH - QSHIFT;
    localparam int AXW    = (DW > 31) ? DW : 31;
    localparam int SMAX   = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
    localparam int SBITS  = $clog2(SMAX + 2);
    localparam int DISTW  = 32 + SMAX;
    localparam int TW     = DISTW - 16 + 25;
    localparam int PRW    = 2 * QE;
    localparam int PW     = PRW + 3;
    localparam int CW     = ((PW > DW) ? PW : DW) + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQX, S_SQY, S_SQRT, S_DIST, S_QMUL, S_QSUM,
        S_YAW0, S_YAW, S_BEAR, S_MAG, S_LIN1, S_LIN2, S_OUT
    } state_t;

    state_t               state_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [QE-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic [AXW-1:0]       ax_reg, ay_reg;
    logic [SBITS-1:0]     s_reg;
    logic [61:0]          sq_reg;
    logic [63:0]          rad_reg;
    logic [33:0]          rem_reg;
    logic [31:0]          root_reg;
    logic [4:0]           cnt_reg;
    logic [2:0]           k_reg;
    logic [DISTW-1:0]     dist_reg;
    logic signed [PRW-1:0] p_reg [8];
    logic signed [PW-1:0] cx_reg, cy_reg;
    logic                 lock_reg;
    logic [31:0]          yaw_reg;
    logic [31:0]          err_reg;
    logic [17:0]          mag_reg;
    logic                 neg_reg, slow_reg;
    logic [40:0]          pl_reg;
    logic [42:0]          pa_reg;
    logic                 out_valid_reg;
    logic signed [31:0]   lin_reg, ang_reg;
    logic                 stopped_reg;

    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   mul_p;
    logic [35:0]          rem_s, trial;
    logic [DISTW-1:0]     dist_w;
    logic signed [PW-1:0] d_w, g_w, absg_w, cx_w, cy_w;
    logic                 c_start, c_sel_quat, c_done;
    logic signed [CW-1:0] c_x, c_y;
    logic [31:0]          c_angle;
    logic signed [DW-1:0] dx_in, dy_in;
    logic [31:0]          mag0_w;
    logic [63:0]          magp_w;
    logic [TW-1:0]        t_w;
    logic [26:0]          ta_w;

    assign dx_in = q_data[QDW-1 -: DW];
    assign dy_in = q_data[QDW-DW-1 -: DW];
    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX:
            begin
                mul_a = {1'b0, ax_reg[30:0]};
                mul_b = {1'b0, ax_reg[30:0]};
            end
            S_SQY:
            begin
                mul_a = {1'b0, ay_reg[30:0]};
                mul_b = {1'b0, ay_reg[30:0]};
            end
            S_QMUL:
            begin
                case (k_reg)
                    3'd0: begin mul_a = 32'(qw_reg); mul_b = 32'(qw_reg); end
                    3'd1: begin mul_a = 32'(qx_reg); mul_b = 32'(qx_reg); end
                    3'd2: begin mul_a = 32'(qy_reg); mul_b = 32'(qy_reg); end
                    3'd3: begin mul_a = 32'(qz_reg); mul_b = 32'(qz_reg); end
                    3'd4: begin mul_a = 32'(qx_reg); mul_b = 32'(qz_reg); end
                    3'd5: begin mul_a = 32'(qw_reg); mul_b = 32'(qy_reg); end
                    3'd6: begin mul_a = 32'(qx_reg); mul_b = 32'(qy_reg); end
                    default: begin mul_a = 32'(qw_reg); mul_b = 32'(qz_reg); end
                endcase
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // square root step, distance and quaternion sums
    always_comb
    begin
        rem_s  = {rem_reg, rad_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        dist_w = DISTW'(root_reg) << s_reg;
        d_w    = PW'(p_reg[0]) + PW'(p_reg[1]) + PW'(p_reg[2]) + PW'(p_reg[3]);
        g_w    = (PW'(p_reg[4]) - PW'(p_reg[5])) <<< 1;
        absg_w = (g_w < 0) ? -g_w : g_w;
        cx_w   = PW'(p_reg[0]) + PW'(p_reg[1]) - PW'(p_reg[2]) - PW'(p_reg[3]);
        cy_w   = (PW'(p_reg[6]) + PW'(p_reg[7])) <<< 1;
    end

    // heading error scaling and speed sums
    always_comb
    begin
        mag0_w = err_reg[31] ? (32'd0 - err_reg) : err_reg;
        magp_w = 64'(mag0_w) * PI_Q30 + (64'd1 << 44);
        t_w    = TW'(dist_reg[DISTW-1:16]) * TW'(cfg.linear_gain) + TW'(pl_reg[40:16]);
        if (slow_reg)
        begin
            t_w = t_w >> 1;
        end
        ta_w = pa_reg[42:16];
    end

    // cordic requests: yaw first (skipped at gimbal lock), then bearing
    assign c_start    = (state_reg == S_YAW0) || ((state_reg == S_YAW) && c_done);
    assign c_sel_quat = (state_reg == S_YAW0) && !lock_reg;
    assign c_x        = c_sel_quat ? CW'(cx_reg) : CW'(dx_reg);
    assign c_y        = c_sel_quat ? CW'(cy_reg) : CW'(dy_reg);

    gtg_cordic #(
        .W     (CW),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .x_in  (c_x),
        .y_in  (c_y),
        .done  (c_done),
        .angle (c_angle)
    );

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.fwd_speed = lin_reg;
    assign out_ch.turn_rate = ang_reg;
    assign out_ch.stopped   = stopped_reg;

    // job sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        dx_reg <= dx_in;
                        dy_reg <= dy_in;
                        qx_reg <= q_data[4*QE-1 -: QE];
                        qy_reg <= q_data[3*QE-1 -: QE];
                        qz_reg <= q_data[2*QE-1 -: QE];
                        qw_reg <= q_data[QE-1:0];
                        ax_reg <= AXW'((dx_in < 0) ? -dx_in : dx_in);
                        ay_reg <= AXW'((dy_in < 0) ? -dy_in : dy_in);
                        s_reg  <= '0;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    // scale both offsets below 2^31
                    if (((ax_reg | ay_reg) >> 31) != '0)
                    begin
                        ax_reg <= ax_reg >> 1;
                        ay_reg <= ay_reg >> 1;
                        s_reg  <= s_reg + SBITS'(1);
                    end
                    else
                    begin
                        state_reg <= S_SQX;
                    end
                end
                S_SQX:
                begin
                    sq_reg    <= mul_p[61:0];
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    rad_reg   <= 64'(sq_reg) + 64'(mul_p[61:0]);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (rem_s >= trial)
                    begin
                        rem_reg  <= 34'(rem_s - trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_s[33:0];
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    rad_reg <= rad_reg << 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_DIST;
                    end
                end
                S_DIST:
                begin
                    dist_reg <= dist_w;
                    k_reg    <= '0;
                    if (dist_w < DISTW'(cfg.stop_distance))
                    begin
                        lin_reg       <= '0;
                        ang_reg       <= '0;
                        stopped_reg   <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_QMUL;
                    end
                end
                S_QMUL:
                begin
                    p_reg[k_reg] <= PRW'(mul_p);
                    k_reg        <= k_reg + 3'd1;
                    if (k_reg == 3'd7)
                    begin
                        state_reg <= S_QSUM;
                    end
                end
                S_QSUM:
                begin
                    cx_reg    <= cx_w;
                    cy_reg    <= cy_w;
                    lock_reg  <= (absg_w >= d_w);
                    state_reg <= S_YAW0;
                end
                S_YAW0:
                begin
                    // gimbal lock skips straight to the bearing run
                    if (lock_reg)
                    begin
                        yaw_reg   <= '0;
                        state_reg <= S_BEAR;
                    end
                    else
                    begin
                        state_reg <= S_YAW;
                    end
                end
                S_YAW:
                begin
                    if (c_done)
                    begin
                        yaw_reg   <= c_angle;
                        state_reg <= S_BEAR;
                    end
                end
                S_BEAR:
                begin
                    if (c_done)
                    begin
                        err_reg   <= c_angle - yaw_reg;
                        state_reg <= S_MAG;
                    end
                end
                S_MAG:
                begin
                    mag_reg   <= magp_w[62:45];
                    neg_reg   <= err_reg[31];
                    state_reg <= S_LIN1;
                end
                S_LIN1:
                begin
                    slow_reg  <= (mag_reg > cfg.slow_heading_threshold);
                    pl_reg    <= 41'(dist_reg[15:0]) * 41'(cfg.linear_gain) +
                                 ((mag_reg > cfg.slow_heading_threshold) ?
                                  41'h10000 : 41'h8000);
                    pa_reg    <= 43'(mag_reg) * 43'(cfg.angular_gain) + 43'h8000;
                    state_reg <= S_LIN2;
                end
                S_LIN2:
                begin
                    lin_reg       <= (t_w > TW'(OUT_MAX)) ? OUT_MAX : t_w[31:0];
                    ang_reg       <= neg_reg ? -(32'(ta_w)) : 32'(ta_w);
                    stopped_reg   <= 1'b0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/go_to_goal_velocity_controller_unit.sv]
// go_to_goal_velocity_controller_unit: top level joining front, job queue and back
// depends on gtg_pkg, gtg_if, gtg_front, gtg_queue, gtg_back
// target updates are taken one word per cycle while the job queue is not full; a pose
// word is offered as a result after the normalize steps, the bit-serial square root,
// 8 quaternion products and two serial cordic runs (yaw, then bearing)
// gimbal lock skips the yaw run; inside stop distance the products and runs are skipped
// poses run one at a time; up to two pose jobs queue behind the one in progress;
// reset clears targets and restores register defaults at once, no clearing pass
`timescale 1ns / 1ps
module go_to_goal_velocity_controller_unit #(
    parameter int COORD_WIDTH  = 32,
    parameter int QUAT_WIDTH   = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    gtg_in_if.sink     in_ch,
    gtg_out_if.source  out_ch,
    gtg_cfg_if.sink    cfg_ch
);
    import gtg_pkg::*;

    localparam int QSHIFT = (QUAT_WIDTH > 30) ? QUAT_WIDTH - 30 : 0;
    localparam int QE     = QUAT_WIDTH - QSHIFT;
    localparam int QDW    = 2 * (COORD_WIDTH + 1) + 4 * QE;

    cfg_t           cfg;
    logic           q_full, q_push, q_pop, q_valid;
    logic [QDW-1:0] q_wdata, q_rdata;

    gtg_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .QUAT_WIDTH  (QUAT_WIDTH),
        .QDW         (QDW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    gtg_queue #(
        .DW (QDW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    gtg_back #(
        .COORD_WIDTH  (COORD_WIDTH),
        .QUAT_WIDTH   (QUAT_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS),
        .QDW          (QDW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

[rtl/gtg_checker.sv]
// gtg_port_checker: port-level assertions on the result channel
// bound to go_to_goal_velocity_controller_unit; no other dependencies
`timescale 1ns / 1ps
module gtg_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_lin,
    input logic [31:0] out_ang,
    input logic        out_stopped
);
    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_lin) && $stable(out_ang) &&
        $stable(out_stopped))
        else $error("result word changed while stalled");

    // a stop word carries zero speeds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stopped |-> out_lin == 32'd0 && out_ang == 32'd0)
        else $error("stop word with nonzero speed");

    // forward speed is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_lin[31])
        else $error("negative linear speed");
endmodule

bind go_to_goal_velocity_controller_unit gtg_port_checker u_gtg_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_lin     (out_ch.fwd_speed),
    .out_ang     (out_ch.turn_rate),
    .out_stopped (out_ch.stopped)
);

[tb/gtg_checker.sv]
// gtg_checker: watches the input, result and config channels of the
// go-to-goal controller, predicts each result and compares; uses gtg_pkg, gtg_if
`timescale 1ns / 1ps
module gtg_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic clk,
    input  logic rst_n,
    gtg_in_if    in_ch,
    gtg_out_if   out_ch,
    gtg_cfg_if   cfg_ch,
    output int   errors,
    output int   pending
);
    import gtg_pkg::*;

    typedef struct {
        logic signed [31:0] lin;
        logic signed [31:0] ang;
        logic               stopped;
    } velocity_t;

    // arctangent of 2^-i as a fraction of a full turn times 2^32
    localparam logic [31:0] ARCTAN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
        32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
        32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
        32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

    cfg_t               regs;
    logic signed [31:0] sched_x, sched_y, oper_x, oper_y;
    logic [31:0]        oper_time;
    logic               oper_valid;
    velocity_t          expected_vel[$];

    assign pending = expected_vel.size();

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // cordic vectoring, binary angle of (x, y)
    function automatic logic [31:0] vector_angle(input longint x, input longint y);
        logic [31:0] z;
        longint      t, xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 32'h4000_0000;
            end
            else
            begin
                x = -y; y = t; z = 32'hC000_0000;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + ARCTAN[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - ARCTAN[i];
            end
        end
        return z;
    endfunction

    function automatic velocity_t steer(input logic [31:0] now,
                                        input logic signed [31:0] px, py,
                                        input logic signed [15:0] qx, qy, qz, qw);
        velocity_t   v;
        longint      tx, ty, dx, dy, d, g, eb, lq, e;
        logic [63:0] ax, ay, m, span, mag, t;
        logic [31:0] bearing, yaw, err;
        int          s;
        logic        slow;
        if (!regs.clock_mode && oper_valid &&
            (now - oper_time) < regs.operator_timeout_ms)
        begin
            tx = oper_x; ty = oper_y;
        end
        else
        begin
            tx = sched_x; ty = sched_y;
        end
        dx = tx - longint'(px);
        dy = ty - longint'(py);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        m = ax > ay ? ax : ay;
        s = 0;
        while ((m >> s) >= 64'h8000_0000)
            s++;
        span = root_floor((ax >> s) * (ax >> s) + (ay >> s) * (ay >> s)) << s;
        v.stopped = 0;
        if (span < {33'd0, regs.stop_distance})
        begin
            v.lin = 0; v.ang = 0; v.stopped = 1;
            return v;
        end
        // yaw, zero at gimbal lock
        d = longint'(qw) * qw + longint'(qx) * qx + longint'(qy) * qy + longint'(qz) * qz;
        g = 2 * (longint'(qx) * qz - longint'(qw) * qy);
        if ((g < 0 ? -g : g) >= d)
            yaw = 0;
        else
            yaw = vector_angle(longint'(qw) * qw + longint'(qx) * qx
                               - longint'(qy) * qy - longint'(qz) * qz,
                               2 * (longint'(qx) * qy + longint'(qw) * qz));
        bearing = vector_angle(dx, dy);
        err = bearing - yaw;
        eb = longint'($signed(err));
        mag = eb < 0 ? -eb : eb;
        mag = (mag * PI_Q30 + (64'd1 << 44)) >> 45;
        e = eb < 0 ? -longint'(mag) : longint'(mag);
        slow = mag > {46'd0, regs.slow_heading_threshold};
        t = (span >> 16) * regs.linear_gain
            + (((span & 64'hFFFF) * regs.linear_gain + (slow ? 64'h10000 : 64'h8000)) >> 16);
        if (slow)
            t = t >> 1;
        v.lin = t > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : t[31:0];
        t = (mag * regs.angular_gain + 64'h8000) >> 16;
        lq = e < 0 ? -longint'(t) : longint'(t);
        if (lq > 64'sh7FFF_FFFF)
            v.ang = 32'sh7FFF_FFFF;
        else if (lq < -64'sh8000_0000)
            v.ang = 32'sh8000_0000;
        else
            v.ang = lq[31:0];
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        velocity_t w;
        int        nerr;
        if (!rst_n)
        begin
            regs.clock_mode             <= 1'b1;
            regs.operator_timeout_ms    <= RST_TIMEOUT;
            regs.stop_distance          <= RST_STOP_DIST;
            regs.slow_heading_threshold <= RST_SLOW_THRESH;
            regs.linear_gain            <= RST_LIN_GAIN;
            regs.angular_gain           <= RST_ANG_GAIN;
            sched_x <= 0; sched_y <= 0; oper_x <= 0; oper_y <= 0;
            oper_time <= 0; oper_valid <= 0;
            errors <= 0;
            expected_vel.delete();
        end
        else
        begin
            nerr = 0;
            // register writes
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_CLOCK_MODE:  regs.clock_mode <= cfg_ch.data[0];
                    REG_TIMEOUT:     regs.operator_timeout_ms <= cfg_ch.data;
                    REG_STOP_DIST:   regs.stop_distance <= cfg_ch.data[30:0];
                    REG_SLOW_THRESH: regs.slow_heading_threshold <= cfg_ch.data[17:0];
                    REG_LIN_GAIN:    regs.linear_gain <= cfg_ch.data[23:0];
                    REG_ANG_GAIN:    regs.angular_gain <= cfg_ch.data[23:0];
                    default: ;
                endcase
            end
            // input words
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.command)
                    CMD_SCHEDULE:
                    begin
                        sched_x <= in_ch.pos_x; sched_y <= in_ch.pos_y;
                    end
                    CMD_OPERATOR:
                    begin
                        oper_x <= in_ch.pos_x; oper_y <= in_ch.pos_y;
                        oper_time <= in_ch.time_ms; oper_valid <= 1'b1;
                    end
                    CMD_POSE:
                        expected_vel.push_back(steer(in_ch.time_ms, in_ch.pos_x,
                            in_ch.pos_y, in_ch.quat_x, in_ch.quat_y,
                            in_ch.quat_z, in_ch.quat_w));
                    default: ;
                endcase
            end
            // result words
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_vel.size() == 0)
                begin
                    $error("result word with nothing expected");
                    nerr++;
                end
                else
                begin
                    w = expected_vel.pop_front();
                    if (out_ch.fwd_speed !== w.lin)
                    begin
                        $error("fwd_speed expected %0d got %0d", w.lin,
                               out_ch.fwd_speed);
                        nerr++;
                    end
                    if (out_ch.turn_rate !== w.ang)
                    begin
                        $error("turn_rate expected %0d got %0d", w.ang,
                               out_ch.turn_rate);
                        nerr++;
                    end
                    if (out_ch.stopped !== w.stopped)
                    begin
                        $error("stopped expected %0d got %0d", w.stopped,
                               out_ch.stopped);
                        nerr++;
                    end
                end
            end
            if (nerr != 0)
                errors <= errors + nerr;
        end
    end
endmodule

[tb/tb_go_to_goal_velocity_controller_unit.sv]
// tb_go_to_goal_velocity_controller_unit: stimulus, sink stalls and verdict
// depends on gtg_pkg, gtg_if, gtg_checker and the controller rtl
`timescale 1ns / 1ps
module tb_go_to_goal_velocity_controller_unit;
    import gtg_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic clk;
    logic rst_n;
    int   errors, pending, idle_cycles;
    bit   quiet, hold_req;
    logic [31:0] now_ms;
    logic signed [31:0] last_x, last_y;

    gtg_in_if  in_ch ();
    gtg_out_if out_ch ();
    gtg_cfg_if cfg_ch ();

    go_to_goal_velocity_controller_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    gtg_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // offer one input word and wait for it to be taken
    task automatic send(input logic [1:0] cmd, input logic [31:0] t,
                        input logic [31:0] x, y, input logic [15:0] qx, qy, qz, qw);
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.time_ms <= t;
        in_ch.pos_x   <= x;
        in_ch.pos_y   <= y;
        in_ch.quat_x  <= qx;
        in_ch.quat_y  <= qy;
        in_ch.quat_z  <= qz;
        in_ch.quat_w  <= qw;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // drain every expected result, then let trailing work finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_regs(input logic cm, input logic [31:0] tmo, stp, thr, lg, ag);
        write_reg(REG_CLOCK_MODE, {31'd0, cm});
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_STOP_DIST, stp);
        write_reg(REG_SLOW_THRESH, thr);
        write_reg(REG_LIN_GAIN, lg);
        write_reg(REG_ANG_GAIN, ag);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return int'($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    // one random word, mostly target updates and poses with random content
    task automatic random_word();
        int          k;
        logic [31:0] x, y;
        logic [15:0] q [4];
        k = $urandom_range(0, 19);
        now_ms = ($urandom_range(0, 15) == 0) ? $urandom : now_ms + $urandom_range(0, 1500);
        x = rand_coord();
        y = rand_coord();
        for (int i = 0; i < 4; i++)
            q[i] = $urandom;
        if ($urandom_range(0, 9) == 0)
            q = '{16'd0, 16'd0, 16'd0, 16'd0};
        if (k < 4)
        begin
            last_x = x; last_y = y;
            send(CMD_SCHEDULE, now_ms, x, y, q[0], q[1], q[2], q[3]);
        end
        else if (k < 8)
        begin
            last_x = x; last_y = y;
            send(CMD_OPERATOR, now_ms, x, y, q[0], q[1], q[2], q[3]);
        end
        else if (k == 8)
            send(CMD_UNUSED, $urandom, x, y, q[0], q[1], q[2], q[3]);
        else
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                x = last_x + $urandom_range(0, 3); y = last_y;
            end
            send(CMD_POSE, now_ms, x, y, q[0], q[1], q[2], q[3]);
        end
    endtask

    // sink stalls, with one long hold-off on request
    initial
    begin
        bit lvl;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                lvl = quiet || $urandom_range(0, 2) != 0;
                out_ch.ready <= lvl;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        quiet = 0;
        hold_req = 0;
        now_ms = 0;
        last_x = 0;
        last_y = 0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.command <= CMD_SCHEDULE;
        in_ch.time_ms <= 0;
        in_ch.pos_x <= 0;
        in_ch.pos_y <= 0;
        in_ch.quat_x <= 0;
        in_ch.quat_y <= 0;
        in_ch.quat_z <= 0;
        in_ch.quat_w <= 0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_CLOCK_MODE;
        cfg_ch.data <= 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset settings
        send(CMD_POSE, 0, 0, 0, 0, 0, 0, 16'h7fff);                  // on target, stop
        send(CMD_POSE, 0, 32'h0001_0000, 0, 0, 0, 0, 0);              // zero quaternion
        send(CMD_SCHEDULE, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0);
        send(CMD_POSE, 5, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
             16'h8000, 16'h8000);                                     // widest vector
        send(CMD_POSE, 6, 32'h8000_0000, 32'h7fff_ffff, 16'h7fff, 16'h7fff,
             16'h7fff, 16'h7fff);
        send(CMD_POSE, 7, 0, 0, 0, 16'h4000, 0, 16'h4000);            // gimbal lock
        send(CMD_POSE, 8, 0, 0, 0, 0, 16'h7fff, 16'h0001);            // near half turn
        send(CMD_POSE, 9, 32'h7fff_0000, 32'h7fff_fff0, 0, 0, 16'h5a82, 16'h5a82);
        send(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
             16'hffff, 16'hffff);                                     // unused command
        send(CMD_OPERATOR, 32'hffff_fff0, 32'h0010_0000, 32'hfff0_0000, 0, 0, 0, 0);
        send(CMD_POSE, 32'h0000_0010, 0, 0, 0, 0, 0, 16'h7fff);       // clock mode on
        settle();

        // operator target with age wrap, fresh and stale
        set_regs(1'b0, 32'd100, 32'd3277, 32'd32768, 32'd65536, 32'd262144);
        send(CMD_POSE, 32'h0000_0010, 0, 0, 0, 0, 0, 16'h7fff);       // age across wrap
        send(CMD_POSE, 32'h0000_0054, 0, 0, 0, 0, 0, 16'h7fff);       // exactly at timeout
        send(CMD_POSE, 32'h0000_0053, 0, 0, 16'h2000, 0, 0, 16'h7000);
        send(CMD_SCHEDULE, 0, 32'hfff0_0000, 32'h0000_0000, 0, 0, 0, 0);
        send(CMD_POSE, 32'h0000_0200, 32'h0000_0800, 0, 0, 0, 0, 16'h7fff);
        settle();

        // random phases, extremes first, long sink hold-off in the third
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_regs(1'b0, 0, 0, 0, 0, 0);
                1: set_regs(1'b1, 32'hffff_ffff, 32'h7fff_ffff, 32'd205887,
                            32'hff_ffff, 32'hff_ffff);
                default: set_regs($urandom_range(0, 3) == 0, $urandom_range(0, 5000),
                                  $urandom_range(0, 1 << 16), $urandom_range(0, 205887),
                                  $urandom_range(0, 24'hff_ffff),
                                  $urandom_range(0, 24'hff_ffff));
            endcase
            if (ph == 2)
                hold_req = 1;
            if (ph == 5)
                quiet = 1;
            for (int n = 0; n < (ph == 1 ? 30 : 100); n++)
                random_word();
            settle();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
